@@ rtl/core/u8d_pkg.sv @@
// Package: shared types, result kinds and lead byte helpers for the UTF-8 decoder.
`default_nettype none

package u8d_pkg;

   localparam int unsigned CONT_DEPTH = 5;

   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_RAW   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   typedef logic [CONT_DEPTH-1:0][7:0] cont_type;

   // open sequence bookkeeping; need counts continuation bytes of the sequence in total
   typedef struct packed {
      logic [7:0] lead;
      logic [2:0] need;
      logic [2:0] have;
   } ctl_type;

   localparam ctl_type CTL_CLEAR = '{lead: 8'h00, need: 3'd0, have: 3'd0};

   // one run of results: raw bytes first, then an optional final result
   typedef struct packed {
      logic [2:0]                 raw_cnt;
      logic [CONT_DEPTH-1:0][7:0] raw;
      logic                       fin;
      logic [30:0]                fin_cp;
      logic [1:0]                 fin_kind;
   } run_type;

   // total length of the sequence that a lead byte opens, 0 if not a lead
   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      priority if (b[7:5] == 3'b110)     len = 3'd2;
      else if (b[7:4] == 4'b1110)        len = 3'd3;
      else if (b[7:3] == 5'b11110)       len = 3'd4;
      else if (b[7:2] == 6'b111110)      len = 3'd5;
      else if (b[7:1] == 7'b1111110)     len = 3'd6;
      else                               len = 3'd0;
      return len;
   endfunction

   // payload mask of the lead byte, keyed by continuation count
   function automatic logic [7:0] lead_mask(input logic [2:0] need);
      logic [7:0] m;
      unique case (need)
         3'd1:    m = 8'h1f;
         3'd2:    m = 8'h0f;
         3'd3:    m = 8'h07;
         3'd4:    m = 8'h03;
         3'd5:    m = 8'h01;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/u8d_ifs.sv @@
// Interfaces: byte request, result and control register channels.
`default_nettype none

interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_data;
   modport source (output valid, output byte_in, output end_of_data, input ready);
   modport sink   (input valid, input byte_in, input end_of_data, output ready);
endinterface

interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] code_point;
   logic [1:0]  kind;
   logic        last_of_run;
   modport source (output valid, output code_point, output kind, output last_of_run,
                   input ready);
   modport sink   (input valid, input code_point, input kind, input last_of_run,
                   output ready);
endinterface

interface u8d_csr_if;
   logic valid;
   logic ready;
   logic force_raw;
   modport source (output valid, output force_raw, input ready);
   modport sink   (input valid, input force_raw, output ready);
endinterface

`default_nettype wire

@@ rtl/core/utf8_stream_decoder.sv @@
// Top level: UTF-8 byte stream decoder with the legacy 5- and 6-byte forms.
//
//   channel | dir | handshake     | word
//   --------+-----+---------------+-------------------------------------------
//   req_ch  | in  | valid / ready | byte_in[7:0], end_of_data
//   rsp_ch  | out | valid / ready | code_point[30:0], kind[1:0], last_of_run
//   csr_ch  | in  | valid / ready | force_raw (always ready)
//
// A byte is decoded in the cycle it is accepted; its results land in the run
// register and show on rsp_ch from the next cycle on, one word per cycle while rsp_ch.ready is high.
// A byte with one result or none does not hold req_ch off: a new byte is taken while
// the last word of the previous run is being taken.
// A run of more than one word (raw replay in force mode, up to 6) holds req_ch off until its last word is taken.
// Reset (synchronous) clears the open sequence, the run and force_raw.
// An rsp_ch stall freezes the run register and, while it holds a word, req_ch too.
`default_nettype none

module utf8_stream_decoder
   import u8d_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   u8d_req_if.sink       req_ch,
   u8d_rsp_if.source     rsp_ch,
   u8d_csr_if.sink       csr_ch
);

   logic     force_ff, force_in;
   ctl_type  ctl_ff, ctl_in;
   cont_type cont_ff, cont_in;
   run_type  run_next;

   // run register: raw words shift out first, then the final word
   logic [2:0]                 raw_cnt_ff, raw_cnt_in;
   logic [CONT_DEPTH-1:0][7:0] raw_ff, raw_in;
   logic                       fin_ff, fin_in;
   logic [30:0]                fin_cp_ff, fin_cp_in;
   logic [1:0]                 fin_kind_ff, fin_kind_in;

   logic accept, pop, load, rsp_last;

   u8d_step u_step (
      .ctl         (ctl_ff),
      .cont        (cont_ff),
      .byte_in     (req_ch.byte_in),
      .end_of_data (req_ch.end_of_data),
      .force_raw   (force_ff),
      .ctl_in      (ctl_in),
      .cont_in     (cont_in),
      .run_in      (run_next)
   );

   assign csr_ch.ready = 1'b1;
   assign force_in     = (csr_ch.valid) ? csr_ch.force_raw : force_ff;

   assign rsp_ch.valid       = (raw_cnt_ff != 3'd0) || fin_ff;
   assign rsp_last           = (raw_cnt_ff == 3'd0) || (raw_cnt_ff == 3'd1 && !fin_ff);
   assign rsp_ch.last_of_run = rsp_last;
   assign rsp_ch.code_point  = (raw_cnt_ff != 3'd0) ? {23'd0, raw_ff[0]} : fin_cp_ff;
   assign rsp_ch.kind        = (raw_cnt_ff != 3'd0) ? KIND_RAW : fin_kind_ff;

   assign pop          = rsp_ch.valid && rsp_ch.ready;
   // free now, or the last word of the run leaves this cycle
   assign req_ch.ready = !rsp_ch.valid || (rsp_ch.ready && rsp_last);
   assign accept       = req_ch.valid && req_ch.ready;
   assign load         = accept && ((run_next.raw_cnt != 3'd0) || run_next.fin);

   always_comb begin
      raw_cnt_in  = raw_cnt_ff;
      raw_in      = raw_ff;
      fin_in      = fin_ff;
      fin_cp_in   = fin_cp_ff;
      fin_kind_in = fin_kind_ff;
      if (load) begin
         raw_cnt_in  = run_next.raw_cnt;
         raw_in      = run_next.raw;
         fin_in      = run_next.fin;
         fin_cp_in   = run_next.fin_cp;
         fin_kind_in = run_next.fin_kind;
      end else if (pop) begin
         if (raw_cnt_ff != 3'd0) begin
            raw_cnt_in = raw_cnt_ff - 3'd1;
            raw_in     = {8'h00, raw_ff[CONT_DEPTH-1:1]};
         end else begin
            fin_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         force_ff   <= 1'b0;
         ctl_ff     <= CTL_CLEAR;
         raw_cnt_ff <= 3'd0;
         fin_ff     <= 1'b0;
      end else begin
         force_ff   <= force_in;
         if (accept) ctl_ff <= ctl_in;
         raw_cnt_ff <= raw_cnt_in;
         fin_ff     <= fin_in;
      end
   end

   // payload: no reset; continuation bytes are read only once written
   always_ff @(posedge clock) begin
      if (accept) cont_ff <= cont_in;
      raw_ff      <= raw_in;
      fin_cp_ff   <= fin_cp_in;
      fin_kind_ff <= fin_kind_in;
   end

`ifndef SYNTHESIS
   a_have_below_need: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.need == 3'd0 && ctl_ff.have == 3'd0) || (ctl_ff.have < ctl_ff.need))
      else $error("collected count not below expected count");

   a_need_range: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.need <= 3'd5)
      else $error("sequence length out of range");

   a_raw_cnt_range: assert property (@(posedge clock) disable iff (reset)
      raw_cnt_ff <= 3'd5)
      else $error("raw replay count out of range");

   a_hold_during_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !(rsp_ch.ready && rsp_last)) |-> !req_ch.ready)
      else $error("byte taken while a run is still pending");

   a_raw_only_forced: assert property (@(posedge clock) disable iff (reset)
      load && run_next.raw_cnt != 3'd0 |-> force_ff)
      else $error("raw replay without force mode");
`endif

endmodule

`default_nettype wire

@@ rtl/core/u8d_step.sv @@
// Per-byte decode: next sequence state and the run of results one byte causes.
`default_nettype none

module u8d_step
   import u8d_pkg::*;
(
   input  ctl_type    ctl,
   input  cont_type   cont,
   input  logic [7:0] byte_in,
   input  logic       end_of_data,
   input  logic       force_raw,
   output ctl_type    ctl_in,
   output cont_type   cont_in,
   output run_type    run_in
);

   logic [2:0]  len;
   ctl_type     fr_ctl;
   logic        fr_fin;
   logic [30:0] fr_cp;
   logic [1:0]  fr_kind;
   logic [2:0]  have_inc;
   logic        is_cont;
   logic [30:0] asm_cp;

   // byte seen with no sequence open
   always_comb begin
      len     = seq_len(byte_in);
      fr_ctl  = CTL_CLEAR;
      fr_fin  = 1'b0;
      fr_cp   = '0;
      fr_kind = KIND_CHAR;
      if (!byte_in[7]) begin
         fr_fin = 1'b1;
         fr_cp  = {23'd0, byte_in};
      end else if (len == 3'd0 || end_of_data) begin
         // stray byte, or a lead cut short right away
         fr_fin  = 1'b1;
         fr_cp   = force_raw ? {23'd0, byte_in} : 31'd0;
         fr_kind = force_raw ? KIND_RAW : KIND_ERROR;
      end else begin
         fr_ctl.lead = byte_in;
         fr_ctl.need = len - 3'd1;
      end
   end

   assign have_inc = ctl.have + 3'd1;
   assign is_cont  = (byte_in[7:6] == 2'b10);

   // the incoming byte stands in for the slot it is about to fill
   always_comb begin
      asm_cp = {23'd0, ctl.lead & lead_mask(ctl.need)};
      for (int i = 0; i < CONT_DEPTH; i++) begin
         if (3'(i) < ctl.need)
            asm_cp = {asm_cp[24:0],
                      (3'(i) == ctl.have) ? byte_in[5:0] : cont[i][5:0]};
      end
   end

   always_comb begin
      ctl_in          = ctl;
      cont_in         = cont;
      run_in.raw_cnt  = 3'd0;
      run_in.raw      = {cont[CONT_DEPTH-2:0], ctl.lead};
      run_in.fin      = 1'b0;
      run_in.fin_cp   = '0;
      run_in.fin_kind = KIND_CHAR;
      priority if (ctl.need == 3'd0) begin
         ctl_in          = fr_ctl;
         run_in.fin      = fr_fin;
         run_in.fin_cp   = fr_cp;
         run_in.fin_kind = fr_kind;
      end else if (is_cont) begin
         cont_in[ctl.have] = byte_in;
         if (have_inc >= ctl.need) begin
            run_in.fin    = 1'b1;
            run_in.fin_cp = asm_cp;
            ctl_in        = CTL_CLEAR;
         end else if (end_of_data) begin
            // cut short: in raw mode give back lead and everything collected, else an error
            ctl_in = CTL_CLEAR;
            if (force_raw) begin
               run_in.raw_cnt = have_inc + 3'd1;
               run_in.raw     = {cont_in[CONT_DEPTH-2:0], ctl.lead};
            end else begin
               run_in.fin      = 1'b1;
               run_in.fin_kind = KIND_ERROR;
            end
         end else begin
            ctl_in.have = have_inc;
         end
      end else begin
         // broken sequence; in raw mode the breaking byte starts over
         if (force_raw) begin
            run_in.raw_cnt  = ctl.have + 3'd1;
            ctl_in          = fr_ctl;
            run_in.fin      = fr_fin;
            run_in.fin_cp   = fr_cp;
            run_in.fin_kind = fr_kind;
         end else begin
            ctl_in          = CTL_CLEAR;
            run_in.fin      = 1'b1;
            run_in.fin_kind = KIND_ERROR;
         end
      end
   end

endmodule

`default_nettype wire
